FILE: rtl/dual_channel_waveform_generator_unit_macros.svh
// Assertion macros shared by the waveform generator RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef DUAL_CHANNEL_WAVEFORM_GENERATOR_UNIT_MACROS_SVH
`define DUAL_CHANNEL_WAVEFORM_GENERATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define DCWG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcwg assertion failed");

// Next-cycle implication, checked out of reset
`define DCWG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcwg assertion failed");

`else

`define DCWG_ASSERT_NOW(lbl, ante, cons)
`define DCWG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/dcwg_pkg.sv
package dcwg_pkg;

  // Default sizes
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;

  // Config field widths
  localparam int STEP_W = 32;
  localparam int AMP_W  = 15;
  localparam int SMP_W  = 16;

  // Q30 sine table constants
  localparam int           ROM_W       = 31;
  localparam longint       ONE_Q30     = 64'sd1073741824;
  localparam logic [63:0]  HALF_PI_Q30 = 64'd1686629713;

  // Taylor divisors (2k)(2k+1), k = 1..12
  localparam logic [9:0] TAYLOR_DIV [12] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
    10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600
  };

  typedef enum logic [1:0] {
    MODE_SINE     = 2'd0,
    MODE_TRIANGLE = 2'd1,
    MODE_SQUARE   = 2'd2,
    MODE_OFF      = 2'd3
  } dcwg_mode_t;

  typedef enum logic [2:0] {
    REG_FREQ_STEP_LEFT     = 3'd0,
    REG_FREQ_STEP_RIGHT    = 3'd1,
    REG_PHASE_OFFSET_LEFT  = 3'd2,
    REG_PHASE_OFFSET_RIGHT = 3'd3,
    REG_AMPLITUDE_LEFT     = 3'd4,
    REG_AMPLITUDE_RIGHT    = 3'd5,
    REG_MODE_LEFT          = 3'd6,
    REG_MODE_RIGHT         = 3'd7
  } dcwg_reg_t;

  // Pipeline control from the top level to each channel
  typedef struct packed {
    logic accept;   // item taken this cycle
    logic restart;  // clear accumulator before this sample
  } dcwg_ctrl_t;

  // Elaboration-time sine in Q30 by truncated integer Taylor series
  function automatic logic [ROM_W-1:0] dcwg_q30_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return ROM_W'(sum);
  endfunction

endpackage

FILE: rtl/dcwg_channel.sv
module dcwg_channel
  import dcwg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dcwg_ctrl_t              ctrl,
  input  logic [STEP_W-1:0]       freq_step,
  input  logic [STEP_W-1:0]       phase_offset,
  input  logic [AMP_W-1:0]        amplitude,
  input  dcwg_mode_t              mode,
  output logic signed [SMP_W-1:0] sample
);

  localparam int ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;
  localparam logic [SINE_TABLE_BITS:0]  TAB_N      = {1'b1, {SINE_TABLE_BITS{1'b0}}};
  localparam logic [PHASE_BITS-1:0]     PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

  typedef logic [ROM_W-1:0] sine_rom_t [ROM_DEPTH];

  // Quarter-wave table, last entry exactly one
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int k = 0; k < ROM_DEPTH - 1; k++) begin
      t[k] = dcwg_q30_sine((64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS);
    end
    t[ROM_DEPTH-1] = ROM_W'(ONE_Q30);
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [PHASE_BITS-1:0]        phase_r;
  logic [PHASE_BITS-1:0]        phase_cur;
  logic [PHASE_BITS-1:0]        p;
  logic [SINE_TABLE_BITS-1:0]   tab_i;
  logic [SINE_TABLE_BITS:0]     rom_addr;
  logic signed [PHASE_BITS-1:0] tri_d_nxt;
  logic signed [SMP_W-1:0]      amp_s;
  logic signed [SMP_W-1:0]      sq_nxt;

  // Stage-1 registers
  logic [ROM_W-1:0]             rom_q_r;
  logic                         neg_s1_r;
  logic signed [PHASE_BITS-1:0] tri_d_r;
  logic signed [SMP_W-1:0]      sq_s1_r;
  dcwg_mode_t                   mode_s1_r;

  // Instantaneous phase for this item
  assign phase_cur = ctrl.restart ? '0 : phase_r;
  assign p         = phase_cur - PHASE_BITS'(phase_offset);
  assign amp_s     = signed'({1'b0, amplitude});

  // Quadrant fold: odd quadrants read the table backward
  assign tab_i    = p[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = p[PHASE_BITS-2] ? (TAB_N - {1'b0, tab_i}) : {1'b0, tab_i};

  // Triangle distance from the nearest half-cycle point
  always_comb begin
    if (p[PHASE_BITS-1:PHASE_BITS-2] == 2'b00) begin
      tri_d_nxt = signed'(p);
    end else if (p[PHASE_BITS-1:PHASE_BITS-2] != 2'b11) begin
      tri_d_nxt = signed'(PHASE_HALF - p);
    end else begin
      tri_d_nxt = signed'(p);
    end
  end

  // Square: zero at the two crossings
  always_comb begin
    if (p == '0 || p == PHASE_HALF) begin
      sq_nxt = '0;
    end else if (p[PHASE_BITS-1]) begin
      sq_nxt = -amp_s;
    end else begin
      sq_nxt = amp_s;
    end
  end

  // Phase accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (ctrl.accept) begin
      phase_r <= phase_cur + PHASE_BITS'(freq_step);
    end
  end

  // Table read and stage-1 data
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      rom_q_r   <= SINE_ROM[rom_addr];
      neg_s1_r  <= p[PHASE_BITS-1];
      tri_d_r   <= tri_d_nxt;
      sq_s1_r   <= sq_nxt;
      mode_s1_r <= mode;
    end
  end

  // Scale by amplitude, floor by arithmetic shift
  logic signed [ROM_W:0]            sin_val;
  logic signed [SMP_W+ROM_W:0]      sin_prod;
  logic signed [SMP_W+ROM_W:0]      sin_shift;
  logic signed [SMP_W+PHASE_BITS-1:0] tri_prod;
  logic signed [SMP_W+PHASE_BITS-1:0] tri_shift;

  assign sin_val   = neg_s1_r ? -signed'({1'b0, rom_q_r}) : signed'({1'b0, rom_q_r});
  assign sin_prod  = amp_s * sin_val;
  assign sin_shift = sin_prod >>> 30;
  assign tri_prod  = amp_s * tri_d_r;
  assign tri_shift = tri_prod >>> (PHASE_BITS - 2);

  always_comb begin
    unique case (mode_s1_r)
      MODE_SINE:     sample = sin_shift[SMP_W-1:0];
      MODE_TRIANGLE: sample = tri_shift[SMP_W-1:0];
      MODE_SQUARE:   sample = sq_s1_r;
      MODE_OFF:      sample = '0;
      default:       sample = '0;
    endcase
  end

endmodule

FILE: rtl/dual_channel_waveform_generator_unit.sv
// Two-channel sine/triangle/square generator, one sample item per cycle while out_stall is low.
// Each accepted item passes the sine table read register, then the output
// register. Throughput: one item per cycle when out_stall is low.
// Reset: both phase accumulators zero, steps/offsets/amplitudes zero, both
// channels off; pipeline empty. No clearing pass, items accepted at once.
`include "dual_channel_waveform_generator_unit_macros.svh"

module dual_channel_waveform_generator_unit
  import dcwg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // sample tick items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_restart_time,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SMP_W-1:0] out_sample_left,
  output logic signed [SMP_W-1:0] out_sample_right,
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [STEP_W-1:0]       cfg_data
);

  logic [STEP_W-1:0] freq_step_left_r, freq_step_right_r;
  logic [STEP_W-1:0] phase_offset_left_r, phase_offset_right_r;
  logic [AMP_W-1:0]  amplitude_left_r, amplitude_right_r;
  dcwg_mode_t        mode_left_r, mode_right_r;

  logic s1_valid_r;
  logic out_valid_r;
  logic signed [SMP_W-1:0] out_sample_left_r, out_sample_right_r;
  logic signed [SMP_W-1:0] smp_left, smp_right;

  logic out_en;
  logic s1_load;
  logic in_accept;
  dcwg_ctrl_t ctrl;

  // Register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_step_left_r     <= '0;
      freq_step_right_r    <= '0;
      phase_offset_left_r  <= '0;
      phase_offset_right_r <= '0;
      amplitude_left_r     <= '0;
      amplitude_right_r    <= '0;
      mode_left_r          <= MODE_OFF;
      mode_right_r         <= MODE_OFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dcwg_reg_t'(cfg_index))
        REG_FREQ_STEP_LEFT:     freq_step_left_r     <= cfg_data;
        REG_FREQ_STEP_RIGHT:    freq_step_right_r    <= cfg_data;
        REG_PHASE_OFFSET_LEFT:  phase_offset_left_r  <= cfg_data;
        REG_PHASE_OFFSET_RIGHT: phase_offset_right_r <= cfg_data;
        REG_AMPLITUDE_LEFT:     amplitude_left_r     <= cfg_data[AMP_W-1:0];
        REG_AMPLITUDE_RIGHT:    amplitude_right_r    <= cfg_data[AMP_W-1:0];
        REG_MODE_LEFT:          mode_left_r          <= dcwg_mode_t'(cfg_data[1:0]);
        REG_MODE_RIGHT:         mode_right_r         <= dcwg_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Pipeline flow: each stage moves when the one after it has room
  assign out_en    = !out_valid_r || !out_stall;
  assign s1_load   = !s1_valid_r || out_en;
  assign in_stall  = !s1_load;
  assign in_accept = in_valid && s1_load;

  assign ctrl.accept  = in_accept;
  assign ctrl.restart = in_restart_time;

  dcwg_channel #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_chan_left (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .freq_step    (freq_step_left_r),
    .phase_offset (phase_offset_left_r),
    .amplitude    (amplitude_left_r),
    .mode         (mode_left_r),
    .sample       (smp_left)
  );

  dcwg_channel #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_chan_right (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .freq_step    (freq_step_right_r),
    .phase_offset (phase_offset_right_r),
    .amplitude    (amplitude_right_r),
    .mode         (mode_right_r),
    .sample       (smp_right)
  );

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_accept;
      end
      if (out_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_sample_left_r  <= smp_left;
      out_sample_right_r <= smp_right;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_left  = out_sample_left_r;
  assign out_sample_right = out_sample_right_r;

  // Input waits only when both stages hold items
  `DCWG_ASSERT_NOW(a_stall_only_full, in_stall, s1_valid_r && out_valid_r && out_stall)
  // An accepted item occupies stage 1 next cycle
  `DCWG_ASSERT_NEXT(a_accept_fills_s1, in_accept, s1_valid_r)
  // A stage-1 item moving on shows up at the output
  `DCWG_ASSERT_NEXT(a_s1_to_out, s1_valid_r && out_en, out_valid_r)

endmodule

FILE: dv/dual_channel_waveform_generator_unit_tb.sv
module dual_channel_waveform_generator_unit_tb
  import dcwg_pkg::*;
();

  localparam int          TAB_SIZE    = 1024;
  localparam logic [63:0] HALF_PI_FIX = 64'd1686629713;
  localparam longint      UNITY_FIX   = 64'sd1073741824;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } sample_pair_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        in_restart_time = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic signed [15:0] out_sample_left;
  logic signed [15:0] out_sample_right;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index       = '0;
  logic [31:0] cfg_data        = '0;

  // Generator state as the testbench sees it
  logic [31:0] step_l, step_r, offset_l, offset_r, accum_l, accum_r;
  logic [14:0] amp_l, amp_r;
  dcwg_mode_t  mode_l, mode_r;
  longint      quarter_sine [0:TAB_SIZE];

  sample_pair_t sample_q [$];
  int           err_count;
  bit           no_idle;
  int unsigned  rx_hold;

  dual_channel_waveform_generator_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart_time (in_restart_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_left (out_sample_left),
    .out_sample_right(out_sample_right),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // Q30 sine by truncated integer Taylor series
  function automatic longint fixed_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > UNITY_FIX) begin
      acc = UNITY_FIX;
    end
    return acc;
  endfunction

  // One channel's sample for instantaneous phase p
  function automatic logic signed [15:0] channel_sample(input logic [31:0] p,
                                                        input logic [14:0] amp,
                                                        input dcwg_mode_t md);
    longint      a;
    longint      s;
    longint      d;
    longint      pl;
    logic [1:0]  quad;
    int unsigned idx;
    a  = amp;
    pl = p;
    case (md)
      MODE_SINE: begin
        quad = p[31:30];
        idx  = p[29:20];
        s    = quad[0] ? quarter_sine[TAB_SIZE - idx] : quarter_sine[idx];
        if (quad[1]) begin
          s = -s;
        end
        return 16'((a * s) >>> 30);
      end
      MODE_TRIANGLE: begin
        if (p < 32'h4000_0000) begin
          d = pl;
        end else if (p < 32'hC000_0000) begin
          d = 64'sd2147483648 - pl;
        end else begin
          d = pl - 64'sd4294967296;
        end
        return 16'((a * d) >>> 30);
      end
      MODE_SQUARE: begin
        if (p == 32'h0 || p == 32'h8000_0000) begin
          return 16'sd0;
        end
        return (p < 32'h8000_0000) ? 16'(a) : 16'(-a);
      end
      default: begin
        return 16'sd0;
      end
    endcase
  endfunction

  // Advance both accumulators by one tick and queue the expected samples
  task automatic predict_tick(input bit restart);
    logic [31:0]  p_l;
    logic [31:0]  p_r;
    sample_pair_t pair;
    if (restart) begin
      accum_l = '0;
      accum_r = '0;
    end
    p_l        = accum_l - offset_l;
    p_r        = accum_r - offset_r;
    pair.left  = channel_sample(p_l, amp_l, mode_l);
    pair.right = channel_sample(p_r, amp_r, mode_r);
    accum_l    = accum_l + step_l;
    accum_r    = accum_r + step_r;
    sample_q.push_back(pair);
  endtask

  // Register write; the block is idle whenever this is called
  task automatic write_reg(input dcwg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_FREQ_STEP_LEFT:     step_l   = data;
      REG_FREQ_STEP_RIGHT:    step_r   = data;
      REG_PHASE_OFFSET_LEFT:  offset_l = data;
      REG_PHASE_OFFSET_RIGHT: offset_r = data;
      REG_AMPLITUDE_LEFT:     amp_l    = data[14:0];
      REG_AMPLITUDE_RIGHT:    amp_r    = data[14:0];
      REG_MODE_LEFT:          mode_l   = dcwg_mode_t'(data[1:0]);
      default:                mode_r   = dcwg_mode_t'(data[1:0]);
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one tick item, after a random gap unless no_idle is set
  task automatic send_tick(input bit restart);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_restart_time <= restart;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_tick(restart);
  endtask

  // Hold off input until every queued sample has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 6))
      0:       return 32'h0;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h1 << $urandom_range(0, 31);
      4:       return $urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Amplitude with random junk above bit 14 half the time
  function automatic logic [31:0] rand_amp_word();
    logic [31:0] amp;
    case ($urandom_range(0, 3))
      0:       amp = 32'd0;
      1:       amp = 32'd32767;
      default: amp = $urandom_range(0, 32767);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      amp = amp | ($urandom & 32'hFFFF_8000);
    end
    return amp;
  endfunction

  function automatic logic [31:0] rand_mode_word();
    return ($urandom & 32'hFFFF_FFFC) | 32'($urandom_range(0, 3));
  endfunction

  // Both channels are off after reset and give zero
  task automatic test_off_after_reset();
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();
  endtask

  // Every shape, exact zero crossings, corners, extremes, masked writes
  task automatic test_directed_shapes();
    write_reg(REG_FREQ_STEP_LEFT, 32'h4000_0000);
    write_reg(REG_FREQ_STEP_RIGHT, 32'h2000_0000);
    write_reg(REG_PHASE_OFFSET_LEFT, 32'h0);
    write_reg(REG_PHASE_OFFSET_RIGHT, 32'h4000_0000);
    write_reg(REG_AMPLITUDE_LEFT, 32'hFFFF_FFFF);
    write_reg(REG_AMPLITUDE_RIGHT, 32'h0001_03E8);
    write_reg(REG_MODE_LEFT, 32'hFFFF_FFFE);
    write_reg(REG_MODE_RIGHT, 32'h0000_0005);
    for (int n = 0; n < 8; n++) begin
      send_tick(n == 4);
    end
    wait_idle();

    // full-scale sine through quadrant edges; right off at full amplitude
    write_reg(REG_FREQ_STEP_LEFT, 32'h0010_0001);
    write_reg(REG_PHASE_OFFSET_LEFT, 32'h4000_0000);
    write_reg(REG_MODE_LEFT, 32'(MODE_SINE));
    write_reg(REG_FREQ_STEP_RIGHT, 32'hFFFF_FFFF);
    write_reg(REG_AMPLITUDE_RIGHT, 32'h0000_7FFF);
    write_reg(REG_MODE_RIGHT, 32'(MODE_OFF));
    for (int n = 0; n < 6; n++) begin
      send_tick(n == 0);
    end
    wait_idle();

    // zero-amplitude triangle; unit-amplitude sine shows floor toward minus
    write_reg(REG_FREQ_STEP_LEFT, 32'h8000_0000);
    write_reg(REG_PHASE_OFFSET_LEFT, 32'hFFFF_FFFF);
    write_reg(REG_AMPLITUDE_LEFT, 32'h0);
    write_reg(REG_MODE_LEFT, 32'(MODE_TRIANGLE));
    write_reg(REG_FREQ_STEP_RIGHT, 32'h4000_0000);
    write_reg(REG_PHASE_OFFSET_RIGHT, 32'h0);
    write_reg(REG_AMPLITUDE_RIGHT, 32'h1);
    write_reg(REG_MODE_RIGHT, 32'(MODE_SINE));
    for (int n = 0; n < 6; n++) begin
      send_tick(n == 0);
    end
    wait_idle();
  endtask

  // Random settings per phase, long runs of ticks with sparse restarts
  task automatic test_random_settings();
    for (int ph = 0; ph < 7; ph++) begin
      no_idle = (ph % 3 == 1);
      write_reg(REG_FREQ_STEP_LEFT, rand_word());
      write_reg(REG_FREQ_STEP_RIGHT, rand_word());
      write_reg(REG_PHASE_OFFSET_LEFT, rand_word());
      write_reg(REG_PHASE_OFFSET_RIGHT, rand_word());
      write_reg(REG_AMPLITUDE_LEFT, rand_amp_word());
      write_reg(REG_AMPLITUDE_RIGHT, rand_amp_word());
      write_reg(REG_MODE_LEFT, rand_mode_word());
      write_reg(REG_MODE_RIGHT, rand_mode_word());
      for (int n = 0; n < 147; n++) begin
        // drain the pipeline once mid-stream
        if (ph == 2 && n == 70) begin
          wait_idle();
        end
        send_tick($urandom_range(0, 15) == 0);
      end
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  // Result checker and output stall driver
  always @(posedge clk) begin
    sample_pair_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (sample_q.size() == 0) begin
        $display("%0t unexpected result item: left %0d right %0d",
                 $time, out_sample_left, out_sample_right);
        err_count++;
      end else begin
        want = sample_q.pop_front();
        if (out_sample_left !== want.left) begin
          $display("%0t sample_left mismatch: expected %0d, actual %0d",
                   $time, want.left, out_sample_left);
          err_count++;
        end
        if (out_sample_right !== want.right) begin
          $display("%0t sample_right mismatch: expected %0d, actual %0d",
                   $time, want.right, out_sample_right);
          err_count++;
        end
      end
      rx_hold = no_idle ? 0 : $urandom_range(0, 7);
    end
    if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    err_count = 0;
    no_idle   = 1'b0;
    rx_hold   = 0;
    for (int i = 0; i < TAB_SIZE; i++) begin
      quarter_sine[i] = fixed_sine((64'(i) * HALF_PI_FIX) >> 10);
    end
    quarter_sine[TAB_SIZE] = UNITY_FIX;
    step_l   = '0;
    step_r   = '0;
    offset_l = '0;
    offset_r = '0;
    amp_l    = '0;
    amp_r    = '0;
    mode_l   = MODE_OFF;
    mode_r   = MODE_OFF;
    accum_l  = '0;
    accum_r  = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_off_after_reset();
    test_directed_shapes();
    test_random_settings();

    wait_idle();
    repeat (10) @(posedge clk);
    if (sample_q.size() == 0 && err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sample_q.size() != 0) begin
        $display("%0t %0d expected result items never arrived", $time, sample_q.size());
      end
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("%0t timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
